>>> design/pts_pkg.sv
// Shared types and constants for the priority thread slot scheduler.
// No dependencies; imported by the controller, the datapath and the top level.
package pts_pkg;

   // Default sizing
   localparam int THREAD_SLOTS_DEF  = 4;
   localparam int PRIORITY_BITS_DEF = 2;

   // Fixed field widths of the stream words
   localparam int OPCODE_W   = 3;
   localparam int NEW_PRIO_W = 2;
   localparam int STATUS_W   = 2;
   localparam int SLOT_IDX_W = 2;
   localparam int OLD_PRIO_W = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Operation codes
   localparam opcode_type OP_CREATE = 3'd0;
   localparam opcode_type OP_YIELD  = 3'd1;
   localparam opcode_type OP_EXIT   = 3'd2;
   localparam opcode_type OP_SETP   = 3'd3;
   localparam opcode_type OP_GETP   = 3'd4;
   localparam opcode_type OP_START  = 3'd5;

   // Result status codes
   localparam status_type STS_OK       = 2'd0;
   localparam status_type STS_FULL     = 2'd1;
   localparam status_type STS_NO_START = 2'd2;
   localparam status_type STS_NO_CUR   = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic take;     // latch a new request word, clear the scan trackers
      logic scan;     // read the slot at scan_ptr this cycle
      logic commit;   // apply the operation and load the result register
   } cmd_type;

endpackage

>>> design/pts_ctrl.sv
// Sequencer for the priority thread slot scheduler: accept, slot scan, drain, finish.
// Depends on pts_pkg; drives the datapath through cmd_type and the scan pointer.
module pts_ctrl
   import pts_pkg::*;
#(
   parameter int THREAD_SLOTS = THREAD_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output cmd_type                         cmd,
   output logic [$clog2(THREAD_SLOTS)-1:0] scan_ptr
);

   localparam int SLOT_W = $clog2(THREAD_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREAD_SLOTS - 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic              valid_ff, valid_in;
   logic              out_free;

   assign out_free = !valid_ff || rsp_tready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = req_tvalid;
            if (req_tvalid) begin
               state_in = S_SCAN;
               ptr_in   = '0;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (ptr_ff == LAST_SLOT) begin
               state_in = S_DRAIN;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // last slot read is evaluated in this cycle
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result word valid flag
   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ptr_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign scan_ptr   = ptr_ff;

endmodule

>>> design/pts_dp.sv
// Datapath for the priority thread slot scheduler: slot table, priority memory,
// scan trackers and result register. Depends on pts_pkg; driven by pts_ctrl.
module pts_dp
   import pts_pkg::*;
#(
   parameter int THREAD_SLOTS  = THREAD_SLOTS_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cmd_type                         cmd,
   input  logic [$clog2(THREAD_SLOTS)-1:0] scan_ptr,
   input  logic [OPCODE_W-1:0]             req_opcode,
   input  logic [NEW_PRIO_W-1:0]           req_new_priority,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [SLOT_IDX_W-1:0]           rsp_slot_index,
   output logic                            rsp_idle,
   output logic [OLD_PRIO_W-1:0]           rsp_old_priority
);

   localparam int SLOT_W = $clog2(THREAD_SLOTS);

   // Slot occupancy: a used slot is running if it is the current one, else runnable
   logic [THREAD_SLOTS-1:0] used_ff;
   logic [SLOT_W-1:0]       cur_ff, cur_in;
   logic                    have_ff, have_in;
   logic                    any_ff, any_in;

   // Latched request
   opcode_type              op_ff;
   logic [PRIORITY_BITS-1:0] np_ff;

   // Priority memory, one read port with registered data
   logic [PRIORITY_BITS-1:0] prio_mem [THREAD_SLOTS];
   logic [PRIORITY_BITS-1:0] rd_data_ff;
   logic [SLOT_W-1:0]        rd_addr;
   logic                     we;
   logic [SLOT_W-1:0]        waddr;

   // Scan trackers
   logic                     rd_valid_ff;
   logic [SLOT_W-1:0]        rd_idx_ff;
   logic                     cap_cur_ff;
   logic [PRIORITY_BITS-1:0] cur_prio_ff;
   logic                     free_found_ff;
   logic [SLOT_W-1:0]        free_idx_ff;
   logic                     best_found_ff;
   logic [SLOT_W-1:0]        best_idx_ff;
   logic [PRIORITY_BITS-1:0] best_prio_ff;
   logic                     eval_used, take_free, take_best;

   // Result
   status_type               res_status;
   logic [SLOT_W-1:0]        res_slot;
   logic                     res_idle;
   logic [PRIORITY_BITS-1:0] res_old;
   logic                     set_used, clr_used;
   status_type               status_ff;
   logic [SLOT_IDX_W-1:0]    slot_ff;
   logic                     idle_ff;
   logic [OLD_PRIO_W-1:0]    old_ff;

   // Memory read: current slot while idle (for set/get), scan slot while scanning
   assign rd_addr = cmd.scan ? scan_ptr : cur_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         prio_mem[waddr] <= np_ff;
      end
      rd_data_ff <= prio_mem[rd_addr];
   end

   // Evaluate the slot read in the previous cycle
   assign eval_used = used_ff[rd_idx_ff];
   assign take_free = rd_valid_ff && !eval_used && !free_found_ff;
   assign take_best = rd_valid_ff && eval_used && !(have_ff && rd_idx_ff == cur_ff)
                      && (!best_found_ff || rd_data_ff > best_prio_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         cap_cur_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan;
         cap_cur_ff  <= cmd.take;
         if (cmd.take) begin
            free_found_ff <= 1'b0;
            best_found_ff <= 1'b0;
         end else begin
            if (take_free) begin
               free_found_ff <= 1'b1;
            end
            if (take_best) begin
               best_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_ptr;
      if (cmd.take) begin
         op_ff <= req_opcode;
         np_ff <= PRIORITY_BITS'(req_new_priority);
      end
      if (cap_cur_ff) begin
         cur_prio_ff <= rd_data_ff;
      end
      if (take_free) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (take_best) begin
         best_idx_ff  <= rd_idx_ff;
         best_prio_ff <= rd_data_ff;
      end
   end

   // Operation outcome, applied on commit
   always_comb begin
      res_status = STS_OK;
      res_slot   = '0;
      res_idle   = 1'b0;
      res_old    = '0;
      cur_in     = cur_ff;
      have_in    = have_ff;
      any_in     = any_ff;
      set_used   = 1'b0;
      clr_used   = 1'b0;
      we         = 1'b0;
      waddr      = cur_ff;
      unique case (op_ff) inside
         OP_CREATE: begin
            any_in = 1'b1;
            if (free_found_ff) begin
               set_used = cmd.commit;
               we       = cmd.commit;
               waddr    = free_idx_ff;
               res_slot = free_idx_ff;
            end else begin
               res_status = STS_FULL;
            end
         end
         OP_YIELD: begin
            if (!have_ff) begin
               res_status = STS_NO_CUR;
            end else if (best_found_ff) begin
               cur_in   = best_idx_ff;
               res_slot = best_idx_ff;
            end else begin
               res_slot = cur_ff;
            end
         end
         OP_EXIT: begin
            if (!have_ff) begin
               res_status = STS_NO_CUR;
            end else begin
               clr_used = cmd.commit;
               if (best_found_ff) begin
                  cur_in   = best_idx_ff;
                  res_slot = best_idx_ff;
               end else begin
                  have_in  = 1'b0;
                  res_idle = 1'b1;
               end
            end
         end
         OP_SETP, OP_GETP: begin
            if (!have_ff) begin
               res_status = STS_NO_CUR;
            end else begin
               res_old = cur_prio_ff;
               we      = cmd.commit && (op_ff == OP_SETP);
            end
         end
         OP_START: begin
            if (!any_ff) begin
               res_status = STS_NO_START;
            end else if (best_found_ff) begin
               // with a current thread this is a yield; otherwise a first dispatch
               cur_in   = best_idx_ff;
               have_in  = 1'b1;
               res_slot = best_idx_ff;
            end else if (have_ff) begin
               res_slot = cur_ff;
            end else begin
               res_idle = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Scheduler state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         cur_ff  <= '0;
         have_ff <= 1'b0;
         any_ff  <= 1'b0;
      end else if (cmd.commit) begin
         cur_ff  <= cur_in;
         have_ff <= have_in;
         any_ff  <= any_in;
         if (set_used) begin
            used_ff[free_idx_ff] <= 1'b1;
         end
         if (clr_used) begin
            used_ff[cur_ff] <= 1'b0;
         end
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= res_status;
         slot_ff   <= SLOT_IDX_W'(res_slot);
         idle_ff   <= res_idle;
         old_ff    <= OLD_PRIO_W'(res_old);
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_slot_index   = slot_ff;
   assign rsp_idle         = idle_ff;
   assign rsp_old_priority = old_ff;

endmodule

>>> design/priority_thread_slot_scheduler.sv
// Priority thread slot scheduler. One request word carries an opcode (create,
// yield, exit, set priority, get priority, start) and a priority; one response
// word comes back for each. Create claims the lowest free slot; yield, exit and
// start dispatch the runnable slot of highest priority, lowest index on ties.
// Each word occupies the block from acceptance to the next acceptance: the
// slots are scanned one per cycle through the single read port of the
// priority memory, then a drain state evaluates the last slot and a finish
// state applies the operation once the response register is free. That
// register lets the next word be accepted while a result waits to be taken.
// No clearing pass is needed after reset.
module priority_thread_slot_scheduler
   import pts_pkg::*;
#(
   parameter int THREAD_SLOTS  = THREAD_SLOTS_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [2:0] opcode, [4:3] new_priority
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [1:0] status, [3:2] slot_index,
                                              // [4] idle, [6:5] old_priority
);

   localparam int SLOT_W = $clog2(THREAD_SLOTS);

   cmd_type               cmd;
   logic [SLOT_W-1:0]     scan_ptr;
   logic [STATUS_W-1:0]   status;
   logic [SLOT_IDX_W-1:0] slot_index;
   logic                  idle;
   logic [OLD_PRIO_W-1:0] old_priority;

   pts_ctrl #(
      .THREAD_SLOTS (THREAD_SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .scan_ptr   (scan_ptr)
   );

   pts_dp #(
      .THREAD_SLOTS  (THREAD_SLOTS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .scan_ptr         (scan_ptr),
      .req_opcode       (req_tdata[2:0]),
      .req_new_priority (req_tdata[4:3]),
      .rsp_status       (status),
      .rsp_slot_index   (slot_index),
      .rsp_idle         (idle),
      .rsp_old_priority (old_priority)
   );

   assign rsp_tdata = {1'b0, old_priority, idle, slot_index, status};

   // An accepted word keeps the block busy until its result is applied
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a word was in flight");

   // Going idle means no thread is running, so no slot is reported
   a_idle_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[3:2] == 2'd0 && rsp_tdata[1:0] == STS_OK)
      else $error("idle result carries a slot or an error");

   // Error results carry no other information
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STS_OK |-> rsp_tdata[6:4] == 3'd0)
      else $error("error result carries idle or priority");

   // The scan overlaps neither the commit nor the take
   a_scan_commit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.scan && cmd.commit) && !(cmd.take && cmd.scan))
      else $error("controller issued overlapping commands");

endmodule
